### sv/nac_pkg.sv
// Package: shared types and constants for the cumulative hazard core.
`timescale 1ns / 1ps
package nac_pkg;
   localparam int MaxSamples = 1024;
   localparam int AddrBits = $clog2(MaxSamples);
   localparam int CountBits = $clog2(MaxSamples + 1);
   localparam int TimeBits = 32;
   localparam int FracBits = 24;
   localparam int HazBits = 32;
   localparam int DivBits = CountBits + FracBits;
   // death and censoring counts packed side by side in one memory word
   localparam int CntW = 2 * CountBits;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_BUILD = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_READY = 2'd2;

   typedef struct packed {
      logic [1:0]          command;
      logic [TimeBits-1:0] sample_time;
      logic                event_flag;
      logic [TimeBits-1:0] query_time;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [HazBits-1:0]   hazard;
      logic [CountBits-1:0] distinct_times;
   } rsp_type;
endpackage

### sv/nac_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module nac_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

### sv/nac_div.sv
// Restoring divider: (numer << FracBits) / denom, one quotient bit a cycle.
`timescale 1ns / 1ps
module nac_div
   import nac_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CountBits-1:0] numer,
   input  logic [CountBits-1:0] denom,
   output logic                 done,
   output logic [DivBits-1:0]   quot
);
   logic [DivBits-1:0]   quot_ff, quot_in;
   logic [CountBits:0]   rem_ff, rem_in;
   logic [CountBits-1:0] den_ff;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 run_ff, run_in, done_ff, done_in;
   logic [CountBits:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[CountBits-1:0], quot_ff[DivBits-1]};
      if (start) begin
         quot_in = {numer, {FracBits{1'b0}}};
         rem_in  = '0;
         cnt_in  = 6'(DivBits);
         run_in  = 1'b1;
      end else if (run_ff) begin
         // shift in next dividend bit, subtract when it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[DivBits-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[DivBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (start) begin
         den_ff <= denom;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

### sv/nelson_aalen_cumulative_hazard_core.sv
// From acceptance to result strobe (n = entries): clear, full store or not ready go to the
// strobe directly; load does a lower-bound search of at most ceil(log2(n+1)) probes, shifts
// entries up and inserts; build runs the 35-bit bit-serial divider per entry; query searches.
// One item at a time; busy stays high until the cycle after the strobe.
// The result strobe rsp_valid is high for one cycle; the receiver cannot stall.
// Synchronous reset empties the table; memory contents are undefined until written.
`timescale 1ns / 1ps
module nelson_aalen_cumulative_hazard_core
   import nac_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_LSRD  = 11'b00000000010,
      S_LSCK  = 11'b00000000100,
      S_SHRD  = 11'b00000001000,
      S_SHWR  = 11'b00000010000,
      S_INS   = 11'b00000100000,
      S_BRD   = 11'b00001000000,
      S_BDIV  = 11'b00010000000,
      S_QRD   = 11'b00100000000,
      S_QCK   = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [CountBits-1:0] entries_ff, entries_in, total_ff, total_in;
   logic                 built_ff, built_in;
   logic [CountBits-1:0] idx_ff, idx_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [CountBits-1:0] mid;
   logic [CountBits-1:0] risk_ff, risk_in;
   logic [HazBits-1:0]   sum_ff, sum_in;
   logic [TimeBits-1:0]  tkey;
   logic [1:0]           st_ff, st_in;
   logic [HazBits-1:0]   hz_ff, hz_in;
   logic                 hit_ff, hit_in;

   // memory ports
   logic                 t_we, c_we, h_we;
   logic [AddrBits-1:0]  addr;
   logic [TimeBits-1:0]  t_wd, t_rd;
   logic [CntW-1:0]      c_wd, c_rd;
   logic [HazBits-1:0]   h_wd, h_rd;
   logic [CntW-1:0]      c_hold_ff, c_hold_in;

   logic                 div_start, div_done;
   logic [DivBits-1:0]   div_q;
   logic [DivBits:0]     sum_wide;
   logic [CountBits:0]   gone;

   nac_ram #(.Width(TimeBits), .Depth(MaxSamples)) u_time (
      .clock(clock), .wr_en(t_we), .addr(addr), .wr_data(t_wd), .rd_data(t_rd));
   nac_ram #(.Width(CntW), .Depth(MaxSamples)) u_cnt (
      .clock(clock), .wr_en(c_we), .addr(addr), .wr_data(c_wd), .rd_data(c_rd));
   nac_ram #(.Width(HazBits), .Depth(MaxSamples)) u_haz (
      .clock(clock), .wr_en(h_we), .addr(addr), .wr_data(h_wd), .rd_data(h_rd));

   nac_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(c_rd[CntW-1:CountBits]), .denom(risk_ff),
      .done(div_done), .quot(div_q));

   assign mid  = CountBits'(({1'b0, lo_ff} + {1'b0, hi_ff} + 1'b1) >> 1);
   assign tkey = (req_ff.command == CMD_QUERY) ? req_ff.query_time : req_ff.sample_time;
   assign sum_wide = {{(DivBits+1-HazBits){1'b0}}, sum_ff} + {1'b0, div_q};
   // samples leaving the risk set at the entry being built
   assign gone = {1'b0, c_hold_ff[CntW-1:CountBits]} + {1'b0, c_hold_ff[CountBits-1:0]};

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      entries_in = entries_ff;
      total_in   = total_ff;
      built_in   = built_ff;
      idx_in     = idx_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      risk_in    = risk_ff;
      sum_in     = sum_ff;
      st_in      = st_ff;
      hz_in      = hz_ff;
      hit_in     = hit_ff;
      c_hold_in  = c_hold_ff;
      t_we = 1'b0; c_we = 1'b0; h_we = 1'b0;
      addr = idx_ff[AddrBits-1:0];
      t_wd = t_rd; c_wd = c_rd; h_wd = sum_ff;
      div_start = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               st_in  = ST_OK;
               hz_in  = '0;
               idx_in = '0;
               unique case (req_data.command)
                  CMD_LOAD: begin
                     if (total_ff == CountBits'(MaxSamples)) begin
                        st_in = ST_FULL;
                        state_in = S_DONE;
                     end else if (entries_ff == '0) begin
                        hit_in = 1'b0;
                        state_in = S_INS;
                     end else begin
                        lo_in = '0;
                        hi_in = entries_ff;
                        hit_in = 1'b0;
                        state_in = S_LSRD;
                     end
                  end
                  CMD_BUILD: begin
                     if (entries_ff == '0) begin
                        st_in = ST_NOT_READY;
                        state_in = S_DONE;
                     end else begin
                        risk_in = total_ff;
                        sum_in = '0;
                        state_in = S_BRD;
                     end
                  end
                  CMD_QUERY: begin
                     if (!built_ff || entries_ff == '0) begin
                        st_in = ST_NOT_READY;
                        state_in = S_DONE;
                     end else begin
                        lo_in = '0;
                        hi_in = entries_ff - 1'b1;
                        state_in = S_QRD;
                     end
                  end
                  CMD_CLEAR: begin
                     entries_in = '0;
                     total_in = '0;
                     built_in = 1'b0;
                     state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         // load: lower-bound search, lo..hi half-open
         S_LSRD: begin
            idx_in = CountBits'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
            addr = idx_in[AddrBits-1:0];
            state_in = S_LSCK;
         end
         S_LSCK: begin
            // hit tracks whether the entry at hi equals the key
            if (t_rd < tkey) lo_in = idx_ff + 1'b1;
            else begin
               hi_in  = idx_ff;
               hit_in = (t_rd == tkey);
            end
            if (t_rd < tkey ? (idx_ff + 1'b1 == hi_ff) : (lo_ff == idx_ff)) begin
               // search finished: position is new lo
               idx_in = (t_rd < tkey) ? idx_ff + 1'b1 : idx_ff;
               lo_in  = idx_in;
               if (hit_in) begin
                  state_in = S_INS;
                  addr = idx_in[AddrBits-1:0];
               end else begin
                  idx_in = entries_ff;
                  state_in = (entries_ff == idx_in && (t_rd < tkey) &&
                              idx_ff + 1'b1 == entries_ff) ? S_INS : S_SHRD;
                  if (state_in == S_INS) idx_in = entries_ff;
               end
            end else begin
               state_in = S_LSRD;
            end
         end
         // shift entries up from the top down to the insert point
         S_SHRD: begin
            if (idx_ff == lo_ff) begin
               state_in = S_INS;
            end else begin
               addr = AddrBits'(idx_ff - 1'b1);
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            t_we = 1'b1; c_we = 1'b1;
            idx_in = idx_ff - 1'b1;
            state_in = S_SHRD;
         end
         S_INS: begin
            // c_rd valid when hit (read issued the cycle before)
            if (hit_ff) begin
               c_wd = c_rd;
            end else begin
               c_wd = '0;
               entries_in = entries_ff + 1'b1;
            end
            if (req_ff.event_flag) c_wd[CntW-1:CountBits] = c_wd[CntW-1:CountBits] + 1'b1;
            else c_wd[CountBits-1:0] = c_wd[CountBits-1:0] + 1'b1;
            t_wd = req_ff.sample_time;
            t_we = 1'b1; c_we = 1'b1;
            total_in = total_ff + 1'b1;
            built_in = 1'b0;
            state_in = S_DONE;
         end
         // build: read counts, divide, accumulate
         S_BRD: begin
            state_in = S_BDIV;
            hit_in = 1'b0;
         end
         S_BDIV: begin
            if (!hit_ff) begin
               hit_in = 1'b1;
               c_hold_in = c_rd;
               if (risk_ff != '0) div_start = 1'b1;
               else begin
                  hit_in = 1'b0;
                  h_we = 1'b1;
                  risk_in = '0;
                  idx_in = idx_ff + 1'b1;
                  state_in = (idx_ff + 1'b1 == entries_ff) ? S_DONE : S_BRD;
                  if (idx_ff + 1'b1 == entries_ff) built_in = 1'b1;
               end
            end else if (div_done) begin
               if (sum_wide > {{(DivBits+1-HazBits){1'b0}}, {HazBits{1'b1}}})
                  sum_in = {HazBits{1'b1}};
               else sum_in = sum_wide[HazBits-1:0];
               h_wd = sum_in;
               h_we = 1'b1;
               risk_in = ({1'b0, risk_ff} < gone) ? '0 : CountBits'({1'b0, risk_ff} - gone);
               hit_in = 1'b0;
               idx_in = idx_ff + 1'b1;
               state_in = (idx_ff + 1'b1 == entries_ff) ? S_DONE : S_BRD;
               if (idx_ff + 1'b1 == entries_ff) built_in = 1'b1;
            end
         end
         // query: search for last time not above key
         S_QRD: begin
            if (lo_ff == hi_ff) begin
               addr = lo_ff[AddrBits-1:0];
               hit_in = 1'b1;
            end else begin
               addr = mid[AddrBits-1:0];
               idx_in = mid;
               hit_in = 1'b0;
            end
            state_in = S_QCK;
         end
         S_QCK: begin
            if (hit_ff) begin
               hz_in = h_rd;
               state_in = S_DONE;
            end else begin
               if (t_rd > tkey) hi_in = idx_ff - 1'b1;
               else lo_in = idx_ff;
               state_in = S_QRD;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         entries_ff <= '0;
         total_ff   <= '0;
         built_ff   <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         entries_ff <= entries_in;
         total_ff   <= total_in;
         built_ff   <= built_in;
         hit_ff     <= hit_in;
      end
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      risk_ff   <= risk_in;
      sum_ff    <= sum_in;
      st_ff     <= st_in;
      hz_ff     <= hz_in;
      c_hold_ff <= c_hold_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_data.status = st_ff;
   assign rsp_data.hazard = hz_ff;
   assign rsp_data.distinct_times = entries_ff;
endmodule
